// ===== hw/rtl/hcd_pkg.sv =====
// Shared types and constants for the HTTP chunked body decoder.
// Holds the parser phase encoding, the control flag bundle and the status codes.
// No dependencies.
package hcd_pkg;

   // Default width of the chunk size accumulator and remaining-byte counter.
   localparam int HCD_SIZE_BITS = 32;

   // Width of the running payload byte total.
   localparam int TOTAL_BITS = 32;

   // Line delimiter characters.
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // Status codes reported with every result word.
   localparam logic [2:0] STATUS_SIZE     = 3'd0;
   localparam logic [2:0] STATUS_DATA     = 3'd1;
   localparam logic [2:0] STATUS_TRAILER  = 3'd2;
   localparam logic [2:0] STATUS_COMPLETE = 3'd3;
   localparam logic [2:0] STATUS_ERROR    = 3'd4;

   // Parser phase, one-hot.
   typedef enum logic [5:0] {
      PH_SIZE     = 6'b000001,
      PH_DATA     = 6'b000010,
      PH_TRAILER  = 6'b000100,
      PH_DONE     = 6'b001000,
      PH_ERROR    = 6'b010000,
      PH_DATA_END = 6'b100000
   } hcd_phase_type;

   // Control state carried between the register block and the byte step logic.
   typedef struct packed {
      hcd_phase_type phase;
      logic          digits_open;
      logic          pending_cr;
      logic          line_nonempty;
   } hcd_flags_type;

endpackage

// ===== hw/rtl/hcd_step.sv =====
// Next-state and result logic for one body byte of the chunked decoder.
// Purely combinational; the registers live in the top level.
// Depends on hcd_pkg.
module hcd_step #(
   parameter int SIZE_BITS = hcd_pkg::HCD_SIZE_BITS
) (
   input  hcd_pkg::hcd_flags_type           flags_cur,
   input  logic [SIZE_BITS-1:0]             size_accum_cur,
   input  logic [SIZE_BITS-1:0]             bytes_left_cur,
   input  logic [hcd_pkg::TOTAL_BITS-1:0]   total_cur,
   input  logic [7:0]                       in_byte,
   output hcd_pkg::hcd_flags_type           flags_next,
   output logic [SIZE_BITS-1:0]             size_accum_next,
   output logic [SIZE_BITS-1:0]             bytes_left_next,
   output logic [hcd_pkg::TOTAL_BITS-1:0]   total_next,
   output logic                             out_valid,
   output logic [7:0]                       out_byte,
   output logic [2:0]                       status
);
   import hcd_pkg::*;

   logic                 is_hex;
   logic [3:0]           hex_val;
   logic                 accum_full;
   logic [SIZE_BITS-1:0] left_dec;

   // Hex digit decode of the incoming byte.
   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      if (in_byte inside {["0":"9"]}) begin
         hex_val = 4'(in_byte - 8'h30);
      end else if (in_byte inside {["a":"f"]}) begin
         hex_val = 4'(in_byte - 8'h57);
      end else if (in_byte inside {["A":"F"]}) begin
         hex_val = 4'(in_byte - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   // Another digit would overflow when the top nibble is already in use.
   assign accum_full = (size_accum_cur[SIZE_BITS-1 -: 4] != 4'd0);
   assign left_dec   = (bytes_left_cur != '0) ? bytes_left_cur - 1'b1 : bytes_left_cur;

   // Phase transitions and counter updates.
   always_comb begin
      flags_next      = flags_cur;
      size_accum_next = size_accum_cur;
      bytes_left_next = bytes_left_cur;
      total_next      = total_cur;
      out_valid       = 1'b0;
      out_byte        = 8'd0;

      case (flags_cur.phase)
         PH_SIZE: begin
            if (flags_cur.pending_cr && in_byte == CHAR_LF) begin
               // A complete size line: start data or the trailer.
               size_accum_next          = '0;
               flags_next.digits_open   = 1'b1;
               flags_next.pending_cr    = 1'b0;
               flags_next.line_nonempty = 1'b0;
               if (size_accum_cur == '0) begin
                  flags_next.phase = PH_TRAILER;
               end else begin
                  bytes_left_next  = size_accum_cur;
                  flags_next.phase = PH_DATA;
               end
            end else begin
               // A lone CR before this byte is plain content and ends the digits.
               if (flags_cur.pending_cr) begin
                  flags_next.pending_cr    = 1'b0;
                  flags_next.line_nonempty = 1'b1;
                  flags_next.digits_open   = 1'b0;
               end
               if (in_byte == CHAR_CR) begin
                  flags_next.pending_cr = 1'b1;
               end else begin
                  flags_next.line_nonempty = 1'b1;
                  if (flags_cur.digits_open && !flags_cur.pending_cr) begin
                     if (!is_hex) begin
                        flags_next.digits_open = 1'b0;
                     end else if (accum_full) begin
                        flags_next.phase = PH_ERROR;
                     end else begin
                        size_accum_next = {size_accum_cur[SIZE_BITS-5:0], hex_val};
                     end
                  end
               end
            end
         end
         PH_DATA: begin
            out_valid = 1'b1;
            out_byte  = in_byte;
            if (total_cur != '1) begin
               total_next = total_cur + 1'b1;
            end
            bytes_left_next = left_dec;
            if (left_dec == '0) begin
               flags_next.phase      = PH_DATA_END;
               flags_next.pending_cr = 1'b0;
            end
         end
         PH_DATA_END: begin
            if (!flags_cur.pending_cr) begin
               if (in_byte == CHAR_CR) begin
                  flags_next.pending_cr = 1'b1;
               end else begin
                  flags_next.phase = PH_ERROR;
               end
            end else if (in_byte == CHAR_LF) begin
               flags_next.phase         = PH_SIZE;
               size_accum_next          = '0;
               flags_next.digits_open   = 1'b1;
               flags_next.pending_cr    = 1'b0;
               flags_next.line_nonempty = 1'b0;
            end else begin
               flags_next.phase = PH_ERROR;
            end
         end
         PH_TRAILER: begin
            if (flags_cur.pending_cr && in_byte == CHAR_LF) begin
               // An empty trailer line ends the message.
               flags_next.pending_cr    = 1'b0;
               flags_next.line_nonempty = 1'b0;
               if (!flags_cur.line_nonempty) begin
                  flags_next.phase = PH_DONE;
               end
            end else begin
               flags_next.pending_cr    = (in_byte == CHAR_CR);
               if (flags_cur.pending_cr || in_byte != CHAR_CR) begin
                  flags_next.line_nonempty = 1'b1;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
            flags_next.phase = PH_ERROR;
         end
      endcase
   end

   // Status as seen after this byte; the terminator wait still reports data.
   always_comb begin
      case (flags_next.phase)
         PH_SIZE:     status = STATUS_SIZE;
         PH_DATA:     status = STATUS_DATA;
         PH_DATA_END: status = STATUS_DATA;
         PH_TRAILER:  status = STATUS_TRAILER;
         PH_DONE:     status = STATUS_COMPLETE;
         default:     status = STATUS_ERROR;
      endcase
   end

endmodule

// ===== hw/rtl/http_chunked_decoder.sv =====
// HTTP/1.1 chunked body decoder: one body byte in, one result word out.
// The result word for each accepted byte is registered in the output register.
// Throughput: one byte per cycle; the parser state and output register both load
// on each accepted byte, and input stalls only while a held result is stalled.
// Reset (synchronous, active high) returns the parser to the size line phase with
// all counters cleared and the output register empty.
module http_chunked_decoder #(
   parameter int SIZE_BITS = hcd_pkg::HCD_SIZE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_in_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_out_valid,
   output logic [7:0]                     rsp_out_byte,
   output logic [2:0]                     rsp_status,
   output logic [hcd_pkg::TOTAL_BITS-1:0] rsp_decoded_total
);
   import hcd_pkg::*;

   hcd_flags_type         flags_ff, flags_in;
   logic [SIZE_BITS-1:0]  size_accum_ff, size_accum_in;
   logic [SIZE_BITS-1:0]  bytes_left_ff, bytes_left_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  out_valid_in;
   logic [7:0]            out_byte_in;
   logic [2:0]            status_in;

   logic                  rsp_valid_ff;
   logic                  out_valid_ff;
   logic [7:0]            out_byte_ff;
   logic [2:0]            status_ff;
   logic [TOTAL_BITS-1:0] decoded_total_ff;
   logic                  req_accept;

   // A new byte is taken unless a finished word is held and stalled.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Byte parsing logic.
   hcd_step #(
      .SIZE_BITS (SIZE_BITS)
   ) u_step (
      .flags_cur       (flags_ff),
      .size_accum_cur  (size_accum_ff),
      .bytes_left_cur  (bytes_left_ff),
      .total_cur       (total_ff),
      .in_byte         (req_in_byte),
      .flags_next      (flags_in),
      .size_accum_next (size_accum_in),
      .bytes_left_next (bytes_left_in),
      .total_next      (total_in),
      .out_valid       (out_valid_in),
      .out_byte        (out_byte_in),
      .status          (status_in)
   );

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.phase         <= PH_SIZE;
         flags_ff.digits_open   <= 1'b1;
         flags_ff.pending_cr    <= 1'b0;
         flags_ff.line_nonempty <= 1'b0;
         size_accum_ff          <= '0;
         bytes_left_ff          <= '0;
         total_ff               <= '0;
      end else if (req_accept) begin
         flags_ff      <= flags_in;
         size_accum_ff <= size_accum_in;
         bytes_left_ff <= bytes_left_in;
         total_ff      <= total_in;
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         out_valid_ff     <= out_valid_in;
         out_byte_ff      <= out_byte_in;
         status_ff        <= status_in;
         decoded_total_ff <= total_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_valid     = out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_status        = status_ff;
   assign rsp_decoded_total = decoded_total_ff;

   // Completion is sticky.
   assert property (@(posedge clock) disable iff (reset)
      (flags_ff.phase == PH_DONE) |=> (flags_ff.phase == PH_DONE))
      else $error("complete phase was left");

   // Error is sticky.
   assert property (@(posedge clock) disable iff (reset)
      (flags_ff.phase == PH_ERROR) |=> (flags_ff.phase == PH_ERROR))
      else $error("error phase was left");

   // A decoded payload byte is always reported with the data status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_valid) |-> (rsp_status == STATUS_DATA))
      else $error("payload byte without data status");

   // The running total never goes backward.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (total_ff >= $past(total_ff)))
      else $error("decoded total decreased");

endmodule
